// ----- rtl/core/bus_presence_conflict_tracker_top_macros.svh -----
// assertion macros for the bus presence conflict tracker checker
`ifndef BUS_PRESENCE_CONFLICT_TRACKER_TOP_MACROS_SVH
`define BUS_PRESENCE_CONFLICT_TRACKER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BPCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpct check failed");

// next-cycle implication, disabled while reset is low
`define BPCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpct check failed");

`endif

// ----- rtl/core/bpct_pkg.sv -----
// types, constants and reset values shared by the presence tracker
`default_nettype none

package bpct_pkg;

    localparam int ADDRESS_COUNT_DEF = 128;
    localparam int DETECT_CYCLES     = 2;

    localparam logic [1:0] DET    = 2'(DETECT_CYCLES);
    localparam logic [1:0] DET_M1 = 2'(DETECT_CYCLES - 1);

    localparam logic [1:0] EV_CONFIRM    = 2'd0;
    localparam logic [1:0] EV_ADD        = 2'd1;
    localparam logic [1:0] EV_REASSIGN   = 2'd2;
    localparam logic [1:0] EV_DISCONNECT = 2'd3;

    localparam logic [2:0] CFG_DELETE_CYCLES = 3'd0;
    localparam logic [2:0] CFG_RANDOM_LOW    = 3'd1;
    localparam logic [2:0] CFG_CONFLICT_LOW  = 3'd2;
    localparam logic [2:0] CFG_CONFLICT_HIGH = 3'd3;
    localparam logic [2:0] CFG_DYNAMIC_LOW   = 3'd4;
    localparam logic [2:0] CFG_DYNAMIC_HIGH  = 3'd5;

    localparam logic [3:0] RST_DELETE_CYCLES = 4'd3;
    localparam logic [6:0] RST_RANDOM_LOW    = 7'd16;
    localparam logic [6:0] RST_CONFLICT_LOW  = 7'd80;
    localparam logic [6:0] RST_CONFLICT_HIGH = 7'd95;
    localparam logic [6:0] RST_DYNAMIC_LOW   = 7'd96;
    localparam logic [6:0] RST_DYNAMIC_HIGH  = 7'd127;

    typedef struct packed {
        logic [3:0] delete_cycles;
        logic [6:0] random_low;
        logic [6:0] conflict_low;
        logic [6:0] conflict_high;
        logic [6:0] dynamic_low;
        logic [6:0] dynamic_high;
    } t_cfg;

    typedef struct packed {
        logic [6:0] addr;
        logic       acked;
        logic       scan;
        logic       in_range;
        logic       dyn;
        logic       rnd;
        logic       above;
        logic       diff_nz;
        logic [4:0] bit_pos;
    } t_job;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] addr;
        logic [4:0] bit_pos;
        logic [6:0] new_a0;
        logic [6:0] new_a1;
        logic       last;
    } t_evt;

    typedef struct packed {
        logic [1:0] cnt;
        t_evt       ev0;
        t_evt       ev1;
    } t_push;

endpackage

`default_nettype wire

// ----- rtl/core/bpct_front.sv -----
// front end: accepts probes, classifies them and queues them for the table stage
`default_nettype none

module bpct_front
    import bpct_pkg::*;
#(
    parameter int ADDRESS_COUNT = ADDRESS_COUNT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cfg        i_cfg,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [6:0]  i_addr,
    input  wire         i_acked,
    input  wire  [31:0] i_id,
    input  wire  [31:0] i_id_inv,
    input  wire         i_scan,
    output logic        o_job_valid,
    output t_job        o_job,
    input  wire         i_job_pop
);

    logic [31:0] diff;
    logic [3:0]  byte_nz;
    logic [1:0]  byte_sel;
    logic [7:0]  sel_byte;
    logic [2:0]  bit_in_byte;
    t_job        job_in;

    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt, n_cnt;
    logic        push;

    assign diff = i_id ^ i_id_inv;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            byte_nz[i] = |diff[8*i +: 8];
        end
        byte_sel = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (byte_nz[i]) begin
                byte_sel = 2'(i);
            end
        end
        sel_byte    = diff[{byte_sel, 3'b000} +: 8];
        bit_in_byte = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (sel_byte[i]) begin
                bit_in_byte = 3'(i);
            end
        end
    end

    always_comb begin
        job_in.addr     = i_addr;
        job_in.acked    = i_acked;
        job_in.scan     = i_scan;
        job_in.in_range = ({1'b0, i_addr} < 8'(ADDRESS_COUNT));
        job_in.dyn      = (i_addr >= i_cfg.dynamic_low) && (i_addr <= i_cfg.dynamic_high);
        job_in.rnd      = (i_addr >= i_cfg.random_low) && (i_addr <= i_cfg.conflict_high);
        job_in.above    = (i_addr > i_cfg.conflict_high);
        job_in.diff_nz  = |byte_nz;
        job_in.bit_pos  = {byte_sel, bit_in_byte};
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_job_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_job_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpct_back.sv -----
// back end: per-address table read-modify-write, conflict counter and event build
`default_nettype none

module bpct_back
    import bpct_pkg::*;
#(
    parameter int ADDRESS_COUNT = ADDRESS_COUNT_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_cfg  i_cfg,
    input  wire   i_job_valid,
    input  t_job  i_job,
    output logic  o_job_pop,
    input  wire   i_room,
    output t_push o_push
);

    localparam int AW = $clog2(ADDRESS_COUNT);

    localparam logic S_RD = 1'b0;
    localparam logic S_EX = 1'b1;

    logic [0:0]   r_state;
    t_job         r_job;
    logic [6:0]   r_off;

    // entry: count in [5:4], miss count in [3:0]
    logic [5:0]   r_mem [ADDRESS_COUNT];
    logic [ADDRESS_COUNT-1:0] r_vld;
    logic [5:0]   r_rd_data;
    logic         r_rd_vld;

    logic         ex;
    logic [AW-1:0] rd_idx, wr_idx;
    logic [1:0]   c, nw, devx;
    logic [3:0]   m, mi, m_n;
    logic         ack_conf, chg_re, chg_add, chg_conf, disc, x_v;
    logic [6:0]   off_cur, a0, a1, off_nx;
    logic [7:0]   off2;
    logic [8:0]   off_sum;
    t_evt         ev_x, ev_y;

    assign ex        = (r_state == S_EX);
    assign o_job_pop = (r_state == S_RD) && i_job_valid && i_room;
    assign rd_idx    = i_job.addr[AW-1:0];
    assign wr_idx    = r_job.addr[AW-1:0];

    always_comb begin
        c        = r_rd_vld ? r_rd_data[5:4] : 2'd0;
        m        = r_rd_vld ? r_rd_data[3:0] : 4'd0;
        nw       = c;
        devx     = c;
        mi       = m;
        m_n      = m;
        ack_conf = 1'b0;
        chg_re   = 1'b0;
        chg_add  = 1'b0;
        chg_conf = 1'b0;
        disc     = 1'b0;
        if (r_job.acked) begin
            if (c == DET) begin
                if (r_job.dyn) begin
                    ack_conf = 1'b1;
                    m_n      = 4'd0;
                end
            end else if (c != 2'd3) begin
                nw = c + 2'd1;
            end
        end else begin
            if (c == DET) begin
                mi = (m != 4'hf) ? m + 4'd1 : m;
                if (mi >= i_cfg.delete_cycles) begin
                    nw = 2'd0;
                    mi = 4'd0;
                end
                m_n = mi;
            end else begin
                devx = 2'd0;
                nw   = 2'd0;
            end
        end
        if (nw != devx) begin
            if (nw == DET) begin
                if (r_job.rnd) begin
                    if (r_job.diff_nz) begin
                        chg_re = 1'b1;
                    end else if (devx == DET_M1) begin
                        chg_add = 1'b1;
                    end
                end
                if (r_job.dyn) begin
                    chg_conf = 1'b1;
                    m_n      = 4'd0;
                end
            end else if (nw == 2'd0) begin
                if (r_job.above && devx == DET) begin
                    disc = 1'b1;
                end
            end
        end
    end

    // conflict address pair and wrapping offset
    always_comb begin
        off_cur = r_job.scan ? 7'd0 : r_off;
        a0      = i_cfg.conflict_low + off_cur;
        a1      = a0 + 7'd1;
        off2    = {1'b0, off_cur} + 8'd2;
        off_sum = {2'b00, i_cfg.conflict_low} + {1'b0, off2};
        off_nx  = (off_sum >= {2'b00, i_cfg.conflict_high}) ? 7'd0 : off2[6:0];
    end

    always_comb begin
        x_v          = ack_conf || chg_re || chg_add || disc;
        ev_x.kind    = ack_conf ? EV_CONFIRM :
                       chg_re   ? EV_REASSIGN :
                       chg_add  ? EV_ADD : EV_DISCONNECT;
        ev_x.addr    = r_job.addr;
        ev_x.bit_pos = chg_re ? r_job.bit_pos : 5'd0;
        ev_x.new_a0  = chg_re ? a0 : 7'd0;
        ev_x.new_a1  = chg_re ? a1 : 7'd0;
        ev_x.last    = !chg_conf;
        ev_y.kind    = EV_CONFIRM;
        ev_y.addr    = r_job.addr;
        ev_y.bit_pos = 5'd0;
        ev_y.new_a0  = 7'd0;
        ev_y.new_a1  = 7'd0;
        ev_y.last    = 1'b1;
        o_push.ev1   = ev_y;
        if (!ex) begin
            o_push.cnt = 2'd0;
            o_push.ev0 = ev_x;
        end else if (x_v && chg_conf) begin
            o_push.cnt = 2'd2;
            o_push.ev0 = ev_x;
        end else if (x_v) begin
            o_push.cnt = 2'd1;
            o_push.ev0 = ev_x;
        end else if (chg_conf) begin
            o_push.cnt = 2'd1;
            o_push.ev0 = ev_y;
        end else begin
            o_push.cnt = 2'd0;
            o_push.ev0 = ev_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RD;
            r_off   <= 7'd0;
            r_vld   <= '0;
        end else begin
            unique case (r_state)
                S_RD: begin
                    if (o_job_pop) begin
                        if (i_job.in_range) begin
                            r_state <= S_EX;
                        end else if (i_job.scan) begin
                            r_off <= 7'd0;
                        end
                    end
                end
                S_EX: begin
                    r_vld[wr_idx] <= 1'b1;
                    r_off         <= chg_re ? off_nx : off_cur;
                    r_state       <= S_RD;
                end
                default: r_state <= S_RD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job     <= i_job;
            r_rd_data <= r_mem[rd_idx];
            r_rd_vld  <= r_vld[rd_idx];
        end
        if (ex) begin
            r_mem[wr_idx] <= {nw, m_n};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpct_outq.sv -----
// four-entry event queue between the table stage and the result stream
`default_nettype none

module bpct_outq
    import bpct_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  wire   i_ready,
    output t_evt  o_evt
);

    t_evt       r_buf [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_evt   = r_buf[r_rp];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + i_push.cnt;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push.cnt} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_buf[r_wp] <= i_push.ev0;
        end
        if (i_push.cnt == 2'd2) begin
            r_buf[r_wp + 2'd1] <= i_push.ev1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bus_presence_conflict_tracker_top.sv -----
// top level of the bus presence and address conflict tracker
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+---------------------------------
//  s_axis    | in        | tvalid / tready         | tdata probe, tuser scan start
//  m_axis    | out       | tvalid / tready / tlast | tdata event, tuser event kind
//  cfg       | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// in the table stage a probe first reads its entry (S_RD), then updates it (S_EX)
// through the single table port; the classify stage and a 2-deep queue sit in front
// reset is synchronous, active low; the table reads as zero until an entry is written
// up to 4 events wait in the output queue; the table stage stalls only when fewer
// than 2 slots are free, the input stalls only when the front queue is full
`default_nettype none

module bus_presence_conflict_tracker_top
    import bpct_pkg::*;
#(
    parameter int ADDRESS_COUNT = ADDRESS_COUNT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // probe_address[6:0], acked[7], id_word[39:8], id_inverse_word[71:40]
    input  wire  [71:0] s_axis_tdata,
    // scan_start[0]
    input  wire  [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // event_address[6:0], differing_bit[11:7], first_new_address[18:12],
    // second_new_address[25:19], zero[31:26]
    output logic [31:0] m_axis_tdata,
    // event_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [6:0]  i_cfg_data
);

    t_cfg  r_cfg;
    logic  job_valid, job_pop, room;
    t_job  job;
    t_push push;
    t_evt  evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delete_cycles <= RST_DELETE_CYCLES;
            r_cfg.random_low    <= RST_RANDOM_LOW;
            r_cfg.conflict_low  <= RST_CONFLICT_LOW;
            r_cfg.conflict_high <= RST_CONFLICT_HIGH;
            r_cfg.dynamic_low   <= RST_DYNAMIC_LOW;
            r_cfg.dynamic_high  <= RST_DYNAMIC_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELETE_CYCLES: r_cfg.delete_cycles <= i_cfg_data[3:0];
                CFG_RANDOM_LOW:    r_cfg.random_low    <= i_cfg_data;
                CFG_CONFLICT_LOW:  r_cfg.conflict_low  <= i_cfg_data;
                CFG_CONFLICT_HIGH: r_cfg.conflict_high <= i_cfg_data;
                CFG_DYNAMIC_LOW:   r_cfg.dynamic_low   <= i_cfg_data;
                CFG_DYNAMIC_HIGH:  r_cfg.dynamic_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bpct_front #(
        .ADDRESS_COUNT (ADDRESS_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_addr      (s_axis_tdata[6:0]),
        .i_acked     (s_axis_tdata[7]),
        .i_id        (s_axis_tdata[39:8]),
        .i_id_inv    (s_axis_tdata[71:40]),
        .i_scan      (s_axis_tuser[0]),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    bpct_back #(
        .ADDRESS_COUNT (ADDRESS_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_room      (room),
        .o_push      (push)
    );

    bpct_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_evt   (evt)
    );

    assign m_axis_tdata = {6'd0, evt.new_a1, evt.new_a0, evt.bit_pos, evt.addr};
    assign m_axis_tuser = evt.kind;
    assign m_axis_tlast = evt.last;

endmodule

`default_nettype wire

// ----- rtl/core/bpct_checker.sv -----
// port-level checks on the tracker's result stream, bound to the top level
`default_nettype none
`include "bus_presence_conflict_tracker_top_macros.svh"

module bpct_checker
    import bpct_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser,
    input wire        m_axis_tlast
);

    // a stalled event holds
    `BPCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // only a reassignment carries a bit position and new addresses
    `BPCT_ASSERT_NOW(a_plain_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != EV_REASSIGN), m_axis_tdata[31:7] == 25'd0)

    // the two conflict addresses are consecutive
    `BPCT_ASSERT_NOW(a_pair_adjacent, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == EV_REASSIGN), m_axis_tdata[25:19] == 7'(m_axis_tdata[18:12] + 7'd1))

    // the first of two events from one probe is an add or a reassignment
    `BPCT_ASSERT_NOW(a_first_of_pair, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, (m_axis_tuser == EV_ADD) || (m_axis_tuser == EV_REASSIGN))

    // the event after a non-final one is a confirm of the same address
    `BPCT_ASSERT_NEXT(a_pair_second, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid || ((m_axis_tuser == EV_CONFIRM) && (m_axis_tdata[6:0] == $past(m_axis_tdata[6:0]))))

endmodule

bind bus_presence_conflict_tracker_top bpct_checker u_bpct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/sv/bus_presence_conflict_tracker_top_tb.sv -----
// testbench for the bus presence conflict tracker: probe streams checked against a predictor
module bus_presence_conflict_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpct_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_PROBES  = 141;

    class presence_scoreboard;
        bit [1:0] confirmed[128];
        bit [1:0] pending[128];
        bit [3:0] misses[128];
        bit [6:0] conflict_offset;
        t_cfg     cfg;
        t_evt     expected_events[$];
        int       errors;
        int       events_checked;
        int       kind_count[4];

        function new();
            cfg.delete_cycles = RST_DELETE_CYCLES;
            cfg.random_low    = RST_RANDOM_LOW;
            cfg.conflict_low  = RST_CONFLICT_LOW;
            cfg.conflict_high = RST_CONFLICT_HIGH;
            cfg.dynamic_low   = RST_DYNAMIC_LOW;
            cfg.dynamic_high  = RST_DYNAMIC_HIGH;
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction

        function void apply_setting(bit [2:0] idx, bit [6:0] value);
            case (idx)
                CFG_DELETE_CYCLES: cfg.delete_cycles = value[3:0];
                CFG_RANDOM_LOW:    cfg.random_low    = value;
                CFG_CONFLICT_LOW:  cfg.conflict_low  = value;
                CFG_CONFLICT_HIGH: cfg.conflict_high = value;
                CFG_DYNAMIC_LOW:   cfg.dynamic_low   = value;
                CFG_DYNAMIC_HIGH:  cfg.dynamic_high  = value;
                default: ;
            endcase
        endfunction

        function t_evt make_event(logic [1:0] kind, bit [6:0] addr, int bit_pos,
                                  bit [6:0] a0, bit [6:0] a1);
            t_evt ev;
            ev.kind    = kind;
            ev.addr    = addr;
            ev.bit_pos = 5'(bit_pos);
            ev.new_a0  = a0;
            ev.new_a1  = a1;
            ev.last    = 1'b0;
            return ev;
        endfunction

        function void note_probe(bit [6:0] addr, bit ack, bit [31:0] id,
                                 bit [31:0] id_copy, bit scan);
            bit [1:0]  dev;
            bit [1:0]  nw;
            bit        dyn;
            int        m;
            int        off;
            int        b;
            bit [31:0] diff;
            t_evt      fresh[$];

            if (scan)
                conflict_offset = '0;
            dev = confirmed[addr];
            nw  = pending[addr];
            dyn = addr >= cfg.dynamic_low && addr <= cfg.dynamic_high;

            if (ack) begin
                if (dev == DET) begin
                    if (dyn) begin
                        fresh.push_back(make_event(EV_CONFIRM, addr, 0, 0, 0));
                        misses[addr] = '0;
                    end
                end else if (nw < 2'd3) begin
                    nw++;
                end
            end else begin
                if (dev == DET) begin
                    m = misses[addr];
                    if (m < 15)
                        m++;
                    if (m >= cfg.delete_cycles) begin
                        nw = '0;
                        m  = 0;
                    end
                    misses[addr] = 4'(m);
                end else begin
                    dev = '0;
                    nw  = '0;
                end
            end

            if (nw != dev) begin
                if (nw == DET) begin
                    if (addr >= cfg.random_low && addr <= cfg.conflict_high) begin
                        diff = id ^ id_copy;
                        if (diff != '0) begin
                            b = 0;
                            while (!diff[b])
                                b++;
                            off = conflict_offset;
                            fresh.push_back(make_event(EV_REASSIGN, addr, b,
                                7'(int'(cfg.conflict_low) + off),
                                7'(int'(cfg.conflict_low) + off + 1)));
                            off += 2;
                            // counter wraps once the next pair would reach the top
                            if (int'(cfg.conflict_low) + off >= int'(cfg.conflict_high))
                                off = 0;
                            conflict_offset = 7'(off);
                        end else if (dev == DET_M1) begin
                            fresh.push_back(make_event(EV_ADD, addr, 0, 0, 0));
                        end
                    end
                    if (dyn) begin
                        fresh.push_back(make_event(EV_CONFIRM, addr, 0, 0, 0));
                        misses[addr] = '0;
                    end
                end else if (nw == 2'd0) begin
                    if (addr > cfg.conflict_high && dev == DET)
                        fresh.push_back(make_event(EV_DISCONNECT, addr, 0, 0, 0));
                end
            end

            confirmed[addr] = nw;
            pending[addr]   = nw;
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                expected_events.push_back(fresh[i]);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_event(bit [1:0] kind, bit [31:0] data, bit last);
            t_evt got;
            t_evt want;

            got.kind    = kind;
            got.addr    = data[6:0];
            got.bit_pos = data[11:7];
            got.new_a0  = data[18:12];
            got.new_a1  = data[25:19];
            got.last    = last;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event kind %0d address %0d", kind, got.addr));
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            kind_count[want.kind]++;
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d (address %0d)",
                                 got.kind, want.kind, want.addr));
            if (got.addr !== want.addr)
                report($sformatf("address %0d, want %0d", got.addr, want.addr));
            if (got.bit_pos !== want.bit_pos)
                report($sformatf("differing bit %0d, want %0d (address %0d)",
                                 got.bit_pos, want.bit_pos, want.addr));
            if (got.new_a0 !== want.new_a0)
                report($sformatf("first new address %0d, want %0d (address %0d)",
                                 got.new_a0, want.new_a0, want.addr));
            if (got.new_a1 !== want.new_a1)
                report($sformatf("second new address %0d, want %0d (address %0d)",
                                 got.new_a1, want.new_a1, want.addr));
            if (got.last !== want.last)
                report($sformatf("last flag %0d, want %0d (address %0d)",
                                 got.last, want.last, want.addr));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [6:0]  i_cfg_data;

    presence_scoreboard sb = new();
    int idle_rate;
    int probes_sent;
    int cycle_count;

    bus_presence_conflict_tracker_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // event side: check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_event(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // event side: ready with random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && idle_rate != 0 && $urandom_range(0, idle_rate - 1) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d events outstanding",
                 cycle_count, sb.outstanding());
        $display("status: fail");
        $finish;
    end

    task automatic send_probe(bit [6:0] addr, bit ack, bit [31:0] id,
                              bit [31:0] id_copy, bit scan);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {id_copy, id, ack, addr};
        s_axis_tuser  <= scan;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_probe(addr, ack, id, id_copy, scan);
        probes_sent++;
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // hold off the probe stream until every event has drained
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [6:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.apply_setting(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_settings(t_cfg c);
        write_reg(CFG_DELETE_CYCLES, 7'(c.delete_cycles));
        write_reg(CFG_RANDOM_LOW, c.random_low);
        write_reg(CFG_CONFLICT_LOW, c.conflict_low);
        write_reg(CFG_CONFLICT_HIGH, c.conflict_high);
        write_reg(CFG_DYNAMIC_LOW, c.dynamic_low);
        write_reg(CFG_DYNAMIC_HIGH, c.dynamic_high);
    endtask

    task automatic directed_probes();
        send_probe(7'd20, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_probe(7'd20, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_probe(7'd30, 1'b1, 32'h0000_0000, 32'h8000_0000, 1'b0);
        send_probe(7'd30, 1'b1, 32'h0000_0000, 32'h8000_0000, 1'b0);
        send_probe(7'd40, 1'b1, 32'h1234_5678, 32'h1234_5679, 1'b0);
        send_probe(7'd40, 1'b1, 32'h1234_5678, 32'h1234_5679, 1'b0);
        send_probe(7'd127, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_probe(7'd127, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_probe(7'd127, 1'b1, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0);
        // misses on a confirmed device until it drops
        repeat (3) send_probe(7'd127, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_probe(7'd0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_probe(7'd0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_probe(7'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // a miss before confirmation restarts detection
        send_probe(7'd50, 1'b1, 32'h5555_5555, 32'h5555_5555, 1'b0);
        send_probe(7'd50, 1'b0, 32'h5555_5555, 32'h5555_5555, 1'b0);
        send_probe(7'd50, 1'b1, 32'h5555_5555, 32'h5555_5555, 1'b0);
        send_probe(7'd50, 1'b1, 32'h5555_5555, 32'h5555_5555, 1'b0);
        // scan start clears the conflict counter
        send_probe(7'd90, 1'b1, 32'h0000_8000, 32'h0000_0000, 1'b1);
        send_probe(7'd90, 1'b1, 32'h0000_8000, 32'h0000_0000, 1'b0);
    endtask

    task automatic send_random(bit [6:0] addr, bit ack);
        bit [31:0] id;
        bit [31:0] id_copy;

        if (idle_rate != 0 && $urandom_range(0, idle_rate - 1) == 0)
            pause_sender($urandom_range(1, 11));
        id = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: id_copy = id;
            5, 6, 7, 8:    id_copy = id ^ (32'h1 << $urandom_range(0, 31));
            default:       id_copy = $urandom;
        endcase
        send_probe(addr, ack, id, id_copy, $urandom_range(0, 15) == 0);
    endtask

    function automatic bit [6:0] pick_address(int slot);
        case (slot % 4)
            0:       return 7'($urandom_range(sb.cfg.random_low, sb.cfg.conflict_high));
            1:       return 7'($urandom_range(sb.cfg.dynamic_low, sb.cfg.dynamic_high));
            2:       return 7'($urandom_range(sb.cfg.conflict_high, 127));
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // mostly attach and detach runs on a few addresses, some stray probes
    task automatic random_phase(int count);
        bit [6:0] pool[6];
        bit [6:0] a;
        int       sent;
        int       n;

        sent = 0;
        for (int i = 0; i < 6; i++)
            pool[i] = pick_address(i);
        while (sent < count) begin
            a = pool[$urandom_range(0, 5)];
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat (2) send_random(a, 1'b1);
                    sent += 2;
                end
                3, 4: begin
                    n = $urandom_range(1, int'(sb.cfg.delete_cycles) + 1);
                    repeat (n) send_random(a, 1'b0);
                    sent += n;
                end
                5, 6, 7: begin
                    send_random(a, $urandom_range(0, 3) != 0);
                    sent++;
                end
                default: begin
                    send_random(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            endcase
            if ($urandom_range(0, 99) == 0)
                wait_quiet();
        end
    endtask

    initial begin
        t_cfg settings[PHASE_COUNT];
        int   rates[PHASE_COUNT];

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        idle_rate     = 0;
        probes_sent   = 0;

        settings[0] = '{RST_DELETE_CYCLES, RST_RANDOM_LOW, RST_CONFLICT_LOW,
                        RST_CONFLICT_HIGH, RST_DYNAMIC_LOW, RST_DYNAMIC_HIGH};
        // every range covers the whole bus, so ranges overlap
        settings[1] = '{4'd1, 7'd0, 7'd0, 7'd127, 7'd0, 7'd127};
        // inverted ranges that never match
        settings[2] = '{4'd15, 7'd127, 7'd127, 7'd0, 7'd127, 7'd0};
        // handed-out addresses wrap past the top of the bus
        settings[3] = '{4'd2, 7'd100, 7'd127, 7'd127, 7'd110, 7'd120};
        // odd-length conflict range
        settings[4] = '{4'd4, 7'd8, 7'd10, 7'd15, 7'd40, 7'd70};
        for (int p = 5; p < 7; p++)
            settings[p] = '{4'($urandom_range(1, 15)), 7'($urandom_range(0, 127)),
                            7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                            7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
        settings[7] = settings[0];
        rates = '{6, 4, 0, 8, 3, 5, 6, 0};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_quiet();
            write_settings(settings[p]);
            idle_rate = rates[p];
            if (p == 0)
                directed_probes();
            random_phase(PHASE_PROBES);
        end
        wait_quiet();

        $display("covered %0d probes over %0d register settings, %0d events checked",
                 probes_sent, PHASE_COUNT, sb.events_checked);
        $display("events seen: confirm %0d, add %0d, reassign %0d, disconnect %0d",
                 sb.kind_count[EV_CONFIRM], sb.kind_count[EV_ADD],
                 sb.kind_count[EV_REASSIGN], sb.kind_count[EV_DISCONNECT]);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- bus_presence_conflict_tracker_top.f -----
+incdir+rtl/core
rtl/core/bpct_pkg.sv
rtl/core/bpct_front.sv
rtl/core/bpct_back.sv
rtl/core/bpct_outq.sv
rtl/core/bus_presence_conflict_tracker_top.sv
rtl/core/bpct_checker.sv
tb/sv/bus_presence_conflict_tracker_top_tb.sv
